>>> sv/apc_pkg.sv
`default_nettype none

package apc_pkg;

    // Significant bits of each input value. Input bits at or above this are ignored.
    localparam int VALUE_BITS = 16;

    // Width of the input ports and of the reported sums.
    localparam int IN_W  = 16;
    localparam int SUM_W = 18;

    // Working width of a value after masking.
    localparam int VAL_W = (VALUE_BITS < IN_W) ? VALUE_BITS : IN_W;

    // Trial divisor width. It holds one past floor(sqrt(2^VAL_W - 1)).
    localparam int D_W = (VAL_W + 1) / 2 + 1;

    // Accumulator width. sigma(n)/n stays below 16 for every n below 2^32,
    // so four extra bits keep the full aliquot sum.
    localparam int ACC_W = VAL_W + 4;

    localparam int CMP_W = (ACC_W > SUM_W) ? ACC_W : SUM_W;
    localparam int CNT_W = $clog2(VAL_W + 1);

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_TEST,
        ST_DIV,
        ST_ACC,
        ST_SAVE,
        ST_OUT
    } apc_state_t;

    typedef struct packed {
        logic capture;
        logic phase_init;
        logic sel_second;
        logic div_start;
        logic accum;
        logic save_sum;
        logic load_result;
    } apc_cmd_t;

    typedef struct packed {
        logic n_small;
        logic sq_over;
        logic div_busy;
        logic rsp_free;
    } apc_status_t;

    function automatic logic [SUM_W-1:0] clamp_sum(input logic [ACC_W-1:0] s);
        logic [CMP_W-1:0] wide;
        wide = CMP_W'(s);
        if (wide > CMP_W'(SUM_MAX)) begin
            return SUM_MAX;
        end
        return SUM_W'(wide);
    endfunction

endpackage

`default_nettype wire

>>> sv/apc_divider.sv
`default_nettype none

module apc_divider
    import apc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [VAL_W-1:0] dividend,
    input  wire logic [VAL_W-1:0] divisor,
    output logic                  busy,
    output logic      [VAL_W-1:0] quotient,
    output logic      [VAL_W-1:0] remainder
);

    // Restoring division, one quotient bit per cycle.
    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [VAL_W-1:0] rem_reg, rem_next;
    logic [VAL_W-1:0] quo_reg, quo_next;
    logic [VAL_W:0]   shifted;
    logic [VAL_W:0]   diff;

    assign shifted = {rem_reg, quo_reg[VAL_W-1]};
    assign diff    = shifted - {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(VAL_W);
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (!diff[VAL_W])
            begin
                rem_next = diff[VAL_W-1:0];
                quo_next = {quo_reg[VAL_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[VAL_W-1:0];
                quo_next = {quo_reg[VAL_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

>>> sv/apc_datapath.sv
`default_nettype none

module apc_datapath
    import apc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire apc_cmd_t          cmd,
    output apc_status_t            status,
    input  wire logic [IN_W-1:0]   first_value,
    input  wire logic [IN_W-1:0]   second_value,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output logic                   pair_is_amicable,
    output logic      [SUM_W-1:0]  first_divisor_sum,
    output logic      [SUM_W-1:0]  second_divisor_sum
);

    logic [VAL_W-1:0] a_reg, b_reg, n_reg;
    logic [D_W-1:0]   d_reg;
    logic [ACC_W-1:0] acc_reg, sa_reg, sb_reg;
    logic             rsp_valid_reg;
    logic             amic_reg;
    logic [SUM_W-1:0] fsum_reg, ssum_reg;

    logic [VAL_W-1:0] quotient, remainder;
    logic             div_busy;
    logic [2*D_W-1:0] d_sq;
    logic [VAL_W-1:0] d_ext;
    logic [ACC_W-1:0] co_term;

    apc_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (n_reg),
        .divisor   (d_ext),
        .busy      (div_busy),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign d_ext = VAL_W'(d_reg);
    assign d_sq  = (2*D_W)'(d_reg) * (2*D_W)'(d_reg);

    // The cofactor counts only when it differs from the divisor and from n itself.
    assign co_term = ((quotient != d_ext) && (quotient != n_reg)) ? ACC_W'(quotient) : '0;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            a_reg <= first_value[VAL_W-1:0];
            b_reg <= second_value[VAL_W-1:0];
        end
        if (cmd.phase_init)
        begin
            n_reg   <= cmd.sel_second ? b_reg : a_reg;
            d_reg   <= D_W'(1);
            acc_reg <= '0;
        end
        else if (cmd.accum)
        begin
            if (remainder == '0)
            begin
                acc_reg <= acc_reg + ACC_W'(d_reg) + co_term;
            end
            d_reg <= d_reg + D_W'(1);
        end
        if (cmd.save_sum)
        begin
            if (cmd.sel_second)
            begin
                sb_reg <= acc_reg;
            end
            else
            begin
                sa_reg <= acc_reg;
            end
        end
        if (cmd.load_result)
        begin
            amic_reg <= (sa_reg == ACC_W'(b_reg)) && (sb_reg == ACC_W'(a_reg));
            fsum_reg <= clamp_sum(sa_reg);
            ssum_reg <= clamp_sum(sb_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load_result)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign status.n_small  = (n_reg[VAL_W-1:1] == '0);
    assign status.sq_over  = (d_sq > (2*D_W)'(n_reg));
    assign status.div_busy = div_busy;
    assign status.rsp_free = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid          = rsp_valid_reg;
    assign pair_is_amicable   = amic_reg;
    assign first_divisor_sum  = fsum_reg;
    assign second_divisor_sum = ssum_reg;

endmodule

`default_nettype wire

>>> sv/apc_ctrl.sv
`default_nettype none

module apc_ctrl
    import apc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire apc_status_t status,
    output apc_cmd_t         cmd
);

    apc_state_t state_reg, state_next;
    logic       phase_reg, phase_next;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = ST_INIT;
                    phase_next = 1'b0;
                end
            end
            ST_INIT: state_next = ST_TEST;
            ST_TEST:
            begin
                if (status.n_small || status.sq_over)
                begin
                    state_next = ST_SAVE;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC: state_next = ST_TEST;
            ST_SAVE:
            begin
                if (phase_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    phase_next = 1'b1;
                    state_next = ST_INIT;
                end
            end
            ST_OUT:
            begin
                if (status.rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.sel_second = phase_reg;
        req_stall      = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall   = 1'b0;
                cmd.capture = req_valid;
            end
            ST_INIT: cmd.phase_init = 1'b1;
            ST_TEST: cmd.div_start = !(status.n_small || status.sq_over);
            ST_DIV:  cmd.accum = 1'b0;
            ST_ACC:  cmd.accum = 1'b1;
            ST_SAVE: cmd.save_sum = 1'b1;
            ST_OUT:  cmd.load_result = status.rsp_free;
            default: req_stall = 1'b1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

>>> sv/amicable_pair_check_top.sv
// Amicable pair check. Each request carries two values; the block returns the aliquot
// sum (sum of proper divisors) of each and a flag that is set when each sum equals
// the other value. A perfect number paired with itself, and the pair (0, 0), set it.
// Request channel: req_valid, req_stall, first_value, second_value. A request is taken
// at a clock edge with req_valid high and req_stall low. Response channel: rsp_valid,
// rsp_stall and the three result ports, taken the same way.
// Each value is scanned with trial divisors d = 1, 2, ... while d*d <= n, and each
// divisor also yields its cofactor. Each trial runs on the shared restoring divider,
// which produces one quotient bit per cycle. A value below 2 needs no trial. One
// request is worked on at a time; the next is taken once the previous result sits
// in the response register, even if it is still stalled. A stalled response holds
// its value; a finished result waits for the register to free before it is loaded.
// Reset is asynchronous and active low; it empties the response register and
// returns the controller to idle.

`default_nettype none

module amicable_pair_check_top
    import apc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    input  wire logic [IN_W-1:0]  first_value,
    input  wire logic [IN_W-1:0]  second_value,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output logic                  pair_is_amicable,
    output logic      [SUM_W-1:0] first_divisor_sum,
    output logic      [SUM_W-1:0] second_divisor_sum
);

    // Commands flow from the controller to the datapath; status flows back.
    apc_cmd_t    cmd;
    apc_status_t status;

    apc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the operands, trial divisor, accumulator, divider and the
    // response register.
    apc_datapath u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .status             (status),
        .first_value        (first_value),
        .second_value       (second_value),
        .rsp_valid          (rsp_valid),
        .rsp_stall          (rsp_stall),
        .pair_is_amicable   (pair_is_amicable),
        .first_divisor_sum  (first_divisor_sum),
        .second_divisor_sum (second_divisor_sum)
    );

endmodule

`default_nettype wire

>>> tb/sv/amicable_pair_monitor.sv
`default_nettype none

module amicable_pair_monitor
    import apc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    input  wire logic             req_stall,
    input  wire logic [IN_W-1:0]  first_value,
    input  wire logic [IN_W-1:0]  second_value,
    input  wire logic             rsp_valid,
    input  wire logic             rsp_stall,
    input  wire logic             pair_is_amicable,
    input  wire logic [SUM_W-1:0] first_divisor_sum,
    input  wire logic [SUM_W-1:0] second_divisor_sum,
    output int                    mismatches,
    output int                    outstanding,
    output int                    results_seen,
    output int                    flags_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [IN_W-1:0]  first_in;
        logic [IN_W-1:0]  second_in;
        logic             amicable;
        logic [SUM_W-1:0] first_sum;
        logic [SUM_W-1:0] second_sum;
    } pair_result_t;

    pair_result_t expected_sums[$];
    int fail_tally;
    int seen_tally;
    int flag_tally;

    function automatic longint unsigned significant_bits(input logic [IN_W-1:0] raw);
        longint unsigned keep;
        keep = (64'd1 << VALUE_BITS) - 64'd1;
        return 64'(raw) & keep;
    endfunction

    // Trial division up to the square root; each divisor below the root also
    // brings its cofactor, except the value itself.
    function automatic longint unsigned proper_divisor_sum(input longint unsigned n);
        longint unsigned total;
        longint unsigned d;
        longint unsigned co;
        total = 0;
        if (n < 2)
        begin
            return 0;
        end
        for (d = 1; d * d <= n; d++)
        begin
            if (n % d == 0)
            begin
                co = n / d;
                total += d;
                if (co != d && co != n)
                begin
                    total += co;
                end
            end
        end
        return total;
    endfunction

    function automatic logic [SUM_W-1:0] port_sum(input longint unsigned s);
        return (s > 64'(SUM_MAX)) ? SUM_MAX : SUM_W'(s);
    endfunction

    task automatic report_mismatch(input string note);
        $display("%0t ns: mismatch: %s", $time, note);
        fail_tally++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        pair_result_t entry;
        pair_result_t want;
        longint unsigned a;
        longint unsigned b;
        longint unsigned sa;
        longint unsigned sb;
        if (!rst_n)
        begin
            expected_sums.delete();
            fail_tally   = 0;
            seen_tally   = 0;
            flag_tally   = 0;
            mismatches   <= 0;
            outstanding  <= 0;
            results_seen <= 0;
            flags_seen   <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                a  = significant_bits(first_value);
                b  = significant_bits(second_value);
                sa = proper_divisor_sum(a);
                sb = proper_divisor_sum(b);
                entry.first_in   = first_value;
                entry.second_in  = second_value;
                entry.amicable   = (sa == b) && (sb == a);
                entry.first_sum  = port_sum(sa);
                entry.second_sum = port_sum(sb);
                expected_sums.push_back(entry);
            end
            if (rsp_valid && !rsp_stall)
            begin
                seen_tally++;
                if (pair_is_amicable)
                begin
                    flag_tally++;
                end
                if (expected_sums.size() == 0)
                begin
                    report_mismatch($sformatf("response (%0b, %0d, %0d) with no request pending",
                        pair_is_amicable, first_divisor_sum, second_divisor_sum));
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (pair_is_amicable !== want.amicable)
                    begin
                        report_mismatch($sformatf("pair (%0d, %0d) flag expected %0b got %0b",
                            want.first_in, want.second_in, want.amicable, pair_is_amicable));
                    end
                    if (first_divisor_sum !== want.first_sum)
                    begin
                        report_mismatch($sformatf("pair (%0d, %0d) first sum expected %0d got %0d",
                            want.first_in, want.second_in, want.first_sum, first_divisor_sum));
                    end
                    if (second_divisor_sum !== want.second_sum)
                    begin
                        report_mismatch($sformatf("pair (%0d, %0d) second sum expected %0d got %0d",
                            want.first_in, want.second_in, want.second_sum, second_divisor_sum));
                    end
                end
            end
            mismatches   <= fail_tally;
            outstanding  <= expected_sums.size();
            results_seen <= seen_tally;
            flags_seen   <= flag_tally;
        end
    end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
`default_nettype none

// Top of the amicable pair testbench. This module only makes stimulus, drives
// the response stall, watches for a hung run and gives the verdict. All
// prediction and comparison lives in the monitor instantiated beside the block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import apc_pkg::*;

    // Cycles without any handshake before the run is declared hung. The limit leaves
    // a wide margin over the slowest request and the long hold-off below.
    localparam int IDLE_LIMIT      = 100000;
    localparam int HOLD_OFF_CYCLES = 3000;
    localparam int DRAIN_CYCLES    = 200;
    localparam int RANDOM_REQUESTS = 70;
    localparam int BURST_REQUESTS  = 8;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             req_valid;
    logic             req_stall;
    logic [IN_W-1:0]  first_value;
    logic [IN_W-1:0]  second_value;
    logic             rsp_valid;
    logic             rsp_stall;
    logic             pair_is_amicable;
    logic [SUM_W-1:0] first_divisor_sum;
    logic [SUM_W-1:0] second_divisor_sum;

    int mismatches;
    int outstanding;
    int results_seen;
    int flags_seen;

    int requests_sent = 0;
    int input_stall_cycles = 0;
    int idle_cycles = 0;

    // Set by the stimulus when the receiver should start its long hold-off.
    bit hold_off_req = 1'b0;
    bit hold_off_done = 1'b0;

    // All amicable pairs with both members below 2^16, and the perfect numbers
    // in the same range.
    int pair_low  [8] = '{220, 1184, 2620, 5020, 6232, 10744, 12285, 17296};
    int pair_high [8] = '{284, 1210, 2924, 5564, 6368, 10856, 14595, 18416};
    int perfect   [4] = '{6, 28, 496, 8128};

    always #5 clk = ~clk;

    amicable_pair_check_top u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req_valid),
        .req_stall          (req_stall),
        .first_value        (first_value),
        .second_value       (second_value),
        .rsp_valid          (rsp_valid),
        .rsp_stall          (rsp_stall),
        .pair_is_amicable   (pair_is_amicable),
        .first_divisor_sum  (first_divisor_sum),
        .second_divisor_sum (second_divisor_sum)
    );

    amicable_pair_monitor u_monitor (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req_valid),
        .req_stall          (req_stall),
        .first_value        (first_value),
        .second_value       (second_value),
        .rsp_valid          (rsp_valid),
        .rsp_stall          (rsp_stall),
        .pair_is_amicable   (pair_is_amicable),
        .first_divisor_sum  (first_divisor_sum),
        .second_divisor_sum (second_divisor_sum),
        .mismatches         (mismatches),
        .outstanding        (outstanding),
        .results_seen       (results_seen),
        .flags_seen         (flags_seen)
    );

    // Gap before a request: half of the requests follow back to back, most of
    // the rest wait a few cycles, and a few wait long enough to let the block
    // go idle.
    function automatic int request_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 5);
        end
        return $urandom_range(20, 150);
    endfunction

    // The block's latency grows with the square root of each value, so most
    // random values are small and only some span the full width. The full-width
    // draws are what toggle the upper input bits.
    function automatic logic [IN_W-1:0] random_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5)
        begin
            return IN_W'($urandom_range(0, 3));
        end
        if (r < 55)
        begin
            return IN_W'($urandom_range(0, 1023));
        end
        if (r < 85)
        begin
            return IN_W'($urandom_range(0, 16383));
        end
        return IN_W'($urandom_range(0, 65535));
    endfunction

    // Offers one request and returns at the clock edge where it is accepted.
    // The valid line is written once per edge: lowered only when a gap follows,
    // otherwise it stays high straight into the next request.
    task automatic send_request(input logic [IN_W-1:0] a, input logic [IN_W-1:0] b, input bit gaps);
        int gap;
        gap = gaps ? request_gap() : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid    <= 1'b1;
        first_value  <= a;
        second_value <= b;
        do
        begin
            @(posedge clk);
        end
        while (req_stall);
        requests_sent++;
    endtask

    // Receiver: alternates stretches of taking every response with short and
    // occasional long stalls. Once the stimulus asks for it, it refuses all
    // responses for a long, fixed number of cycles so the block fills up.
    initial
    begin
        bit stall_now;
        int stretch;
        int r;
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                stall_now = 1'b1;
                stretch = HOLD_OFF_CYCLES;
                hold_off_done = 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    stall_now = 1'b0;
                    stretch = $urandom_range(1, 40);
                end
                else if (r < 90)
                begin
                    stall_now = 1'b1;
                    stretch = $urandom_range(1, 4);
                end
                else
                begin
                    stall_now = 1'b1;
                    stretch = $urandom_range(20, 200);
                end
            end
            rsp_stall <= stall_now;
            repeat (stretch) @(posedge clk);
        end
    end

    // Watchdog: any cycle with a handshake on either channel resets the count.
    always @(posedge clk)
    begin
        if (req_valid && req_stall)
        begin
            input_stall_cycles++;
        end
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Timeout: no request or response moved for %0d cycles, %0d still expected.",
                IDLE_LIMIT, outstanding);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        int i;
        int kind;
        int k;
        int x;
        int y;
        logic [IN_W-1:0] near;

        rst_n        <= 1'b0;
        req_valid    <= 1'b0;
        first_value  <= '0;
        second_value <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests: zero and one, the smallest pairs, perfect numbers
        // with themselves, known amicable pairs in both orders, near misses,
        // the largest values and values whose aliquot sum exceeds 16 bits.
        send_request(16'd0, 16'd0, 1'b0);
        send_request(16'd1, 16'd1, 1'b0);
        send_request(16'd0, 16'd1, 1'b0);
        send_request(16'd2, 16'd3, 1'b1);
        send_request(16'd220, 16'd284, 1'b0);
        send_request(16'd284, 16'd220, 1'b1);
        send_request(16'd6, 16'd6, 1'b0);
        send_request(16'd28, 16'd28, 1'b0);
        send_request(16'd496, 16'd496, 1'b1);
        send_request(16'd8128, 16'd8128, 1'b0);
        send_request(16'd6, 16'd28, 1'b0);
        send_request(16'd220, 16'd220, 1'b0);
        send_request(16'd221, 16'd284, 1'b1);
        send_request(16'd1184, 16'd1210, 1'b0);
        send_request(16'd12285, 16'd14595, 1'b0);
        send_request(16'd17296, 16'd18416, 1'b1);
        send_request(16'hFFFF, 16'hFFFF, 1'b0);
        send_request(16'hFFFF, 16'd0, 1'b0);
        send_request(16'd0, 16'hFFFF, 1'b1);
        send_request(16'h8000, 16'd1, 1'b0);
        send_request(16'd65534, 16'd65521, 1'b0);
        send_request(16'd55440, 16'd45360, 1'b1);
        send_request(16'hAAAA, 16'h5555, 1'b0);

        // Back-pressure: the receiver holds off while small requests keep coming
        // back to back, so the response register fills and the block has to
        // stall its request input.
        hold_off_req = 1'b1;
        for (i = 0; i < BURST_REQUESTS; i++)
        begin
            send_request(IN_W'($urandom_range(2, 200)), IN_W'($urandom_range(2, 200)), 1'b0);
        end

        // Random requests. Fewer than half are real amicable pairs, perfect numbers or
        // near misses of a pair, so the flag is exercised both ways; most of the rest
        // carry arbitrary values.
        for (i = 0; i < RANDOM_REQUESTS; i++)
        begin
            kind = $urandom_range(0, 99);
            k = $urandom_range(0, 7);
            if (kind < 20)
            begin
                if ($urandom_range(0, 1))
                begin
                    send_request(IN_W'(pair_low[k]), IN_W'(pair_high[k]), 1'b1);
                end
                else
                begin
                    send_request(IN_W'(pair_high[k]), IN_W'(pair_low[k]), 1'b1);
                end
            end
            else if (kind < 30)
            begin
                x = perfect[$urandom_range(0, 3)];
                send_request(IN_W'(x), IN_W'(x), 1'b1);
            end
            else if (kind < 40)
            begin
                // One member of a pair nudged off by a little.
                near = IN_W'(pair_low[k] + $urandom_range(1, 3));
                if ($urandom_range(0, 1))
                begin
                    send_request(near, IN_W'(pair_high[k]), 1'b1);
                end
                else
                begin
                    send_request(IN_W'(pair_high[k]), near, 1'b1);
                end
            end
            else if (kind < 45)
            begin
                // Members of two pairs, which may be the same pair, or two different perfect numbers.
                x = $urandom_range(0, 7);
                y = $urandom_range(0, 3);
                if ($urandom_range(0, 1))
                begin
                    send_request(IN_W'(pair_low[k]), IN_W'(pair_high[x]), 1'b1);
                end
                else
                begin
                    send_request(IN_W'(perfect[y]), IN_W'(perfect[(y + 1) % 4]), 1'b1);
                end
            end
            else
            begin
                send_request(random_value(), random_value(), 1'b1);
            end
        end
        req_valid <= 1'b0;

        // Wait for every expected response, then a while longer so that any
        // stray extra response would still show up as a mismatch.
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d requests and %0d checked responses, %0d of them amicable.",
            requests_sent, results_seen, flags_seen);
        $display("The request input was stalled for %0d cycles; %0d mismatches were found.",
            input_stall_cycles, mismatches);
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire
